// File: hdl/lebu_pkg.sv
// Shared types and constants for the line edit buffer unit.
// Holds the command codes, key codes and the structs for the front-to-back queue and the back's status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lebu_pkg;

   // Default line store depth; the store holds at most LINE_DEPTH_DEF-1 characters
   localparam int LINE_DEPTH_DEF = 64;
   // Width of the fill count in the status struct (enough for the default depth)
   localparam int FILL_W = 6;

   // Key codes, by their low five bits
   localparam logic [4:0] KEY_CTRL_C = 5'h03;
   localparam logic [4:0] KEY_CTRL_D = 5'h04;
   localparam logic [4:0] KEY_CTRL_H = 5'h08;
   localparam logic [4:0] KEY_CTRL_J = 5'h0A;
   localparam logic [4:0] KEY_CTRL_M = 5'h0D;
   localparam logic [4:0] KEY_CTRL_U = 5'h15;
   localparam logic [4:0] KEY_CTRL_W = 5'h17;
   localparam logic [4:0] KEY_DEL    = 5'h1F;

   localparam logic [7:0] KEY_PRINT_LO = 8'h20;
   localparam logic [7:0] KEY_PRINT_HI = 8'h7E;
   localparam logic [6:0] CHAR_SPACE   = 7'h20;

   // Command codes from front to back
   localparam logic [2:0] OP_APPEND    = 3'd0;
   localparam logic [2:0] OP_BACK      = 3'd1;
   localparam logic [2:0] OP_CLEAR     = 3'd2;
   localparam logic [2:0] OP_WERASE    = 3'd3;
   localparam logic [2:0] OP_END_OK    = 3'd4;
   localparam logic [2:0] OP_END_ABORT = 3'd5;

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] ch;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qout_type;

   typedef struct packed {
      logic              idle;
      logic [FILL_W-1:0] fill;
   } stat_type;

endpackage
`default_nettype wire

// File: hdl/lebu_front.sv
// Front part of the line edit buffer: accepts key beats, classifies them and queues commands.
// Depends on lebu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lebu_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [7:0]        req_key_byte,
   output lebu_pkg::qout_type     q_out,
   input  wire logic              q_pop
);
   import lebu_pkg::*;

   localparam int QD = 2;

   cmd_type    cmd_dec;
   logic       keep;
   logic       push;
   logic       pop;
   cmd_type    slot_ff [QD];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   // Classify the key byte
   always_comb begin
      cmd_dec.op = OP_APPEND;
      cmd_dec.ch = req_key_byte[6:0];
      keep       = 1'b0;
      if (req_key_byte[7]) begin
         keep = 1'b0;
      end else if (req_key_byte >= KEY_PRINT_LO && req_key_byte <= KEY_PRINT_HI) begin
         keep = 1'b1;
      end else begin
         case (req_key_byte[4:0]) inside
            KEY_CTRL_C: begin
               cmd_dec.op = OP_END_ABORT;
               keep       = 1'b1;
            end
            KEY_CTRL_D, KEY_CTRL_J, KEY_CTRL_M: begin
               cmd_dec.op = OP_END_OK;
               keep       = 1'b1;
            end
            KEY_CTRL_H, KEY_DEL: begin
               cmd_dec.op = OP_BACK;
               keep       = 1'b1;
            end
            KEY_CTRL_U: begin
               cmd_dec.op = OP_CLEAR;
               keep       = 1'b1;
            end
            KEY_CTRL_W: begin
               cmd_dec.op = OP_WERASE;
               keep       = 1'b1;
            end
            default: begin
               keep = 1'b0;
            end
         endcase
      end
   end

   assign req_stall = (count_ff == 2'(QD));
   assign push      = req_valid && !req_stall && keep;
   assign pop       = q_pop && (count_ff != 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

endmodule
`default_nettype wire

// File: hdl/lebu_back.sv
// Back part of the line edit buffer: runs queued commands on the line store and drives results.
// Depends on lebu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lebu_back #(
   parameter int LINE_DEPTH = lebu_pkg::LINE_DEPTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lebu_pkg::qout_type q_in,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [6:0]              rsp_line_char,
   output logic                    rsp_run_last,
   output logic                    rsp_line_empty,
   output logic                    rsp_line_aborted,
   output lebu_pkg::stat_type      stat
);
   import lebu_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [AW-1:0] FULL = AW'(LINE_DEPTH - 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRD   = 3'd1;
   localparam logic [2:0] S_WCMP  = 3'd2;
   localparam logic [2:0] S_EMPTY = 3'd3;
   localparam logic [2:0] S_ERD   = 3'd4;
   localparam logic [2:0] S_EOUT  = 3'd5;

   logic [6:0]    mem [LINE_DEPTH];
   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] k_ff, k_in;
   logic          phase_ff, phase_in;
   logic          abort_ff, abort_in;
   logic [AW-1:0] rd_addr;
   logic [6:0]    rd_data_ff;
   logic          wr_en;
   logic          is_space;
   logic          out_free;
   logic          out_load;
   logic [6:0]    ld_char;
   logic          ld_last;
   logic          ld_empty;
   logic          valid_ff;
   logic [6:0]    char_ff;
   logic          last_ff;
   logic          empty_ff;
   logic          aborted_ff;

   assign out_free = !valid_ff || !rsp_stall;
   assign is_space = (rd_data_ff == CHAR_SPACE);
   assign rd_addr  = (state_ff == S_ERD || state_ff == S_EOUT) ? k_ff : fill_ff - AW'(1);

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      k_in     = k_ff;
      phase_in = phase_ff;
      abort_in = abort_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      out_load = 1'b0;
      ld_char  = rd_data_ff;
      ld_last  = 1'b0;
      ld_empty = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_in.valid) begin
               q_pop = 1'b1;
               case (q_in.cmd.op)
                  OP_APPEND: begin
                     if (fill_ff != FULL) begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + AW'(1);
                     end
                  end
                  OP_BACK: begin
                     if (fill_ff != '0) begin
                        fill_in = fill_ff - AW'(1);
                     end
                  end
                  OP_CLEAR: begin
                     fill_in = '0;
                  end
                  OP_WERASE: begin
                     phase_in = 1'b0;
                     state_in = S_WRD;
                  end
                  OP_END_OK, OP_END_ABORT: begin
                     abort_in = (q_in.cmd.op == OP_END_ABORT);
                     k_in     = '0;
                     state_in = (fill_ff == '0) ? S_EMPTY : S_ERD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WRD: begin
            state_in = (fill_ff == '0) ? S_IDLE : S_WCMP;
         end
         S_WCMP: begin
            // Spaces go in the first pass, the word before them in the second
            if (is_space != phase_ff) begin
               fill_in  = fill_ff - AW'(1);
               state_in = S_WRD;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               out_load = 1'b1;
               ld_char  = 7'd0;
               ld_last  = 1'b1;
               ld_empty = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERD: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (out_free) begin
               out_load = 1'b1;
               ld_last  = (k_ff == fill_ff - AW'(1));
               if (ld_last) begin
                  fill_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + AW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         if (out_load) begin
            valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff     <= k_in;
      phase_ff <= phase_in;
      abort_ff <= abort_in;
      if (out_load) begin
         char_ff    <= ld_char;
         last_ff    <= ld_last;
         empty_ff   <= ld_empty;
         aborted_ff <= abort_ff;
      end
   end

   // Line store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[fill_ff] <= q_in.cmd.ch;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid        = valid_ff;
   assign rsp_line_char    = char_ff;
   assign rsp_run_last     = last_ff;
   assign rsp_line_empty   = empty_ff;
   assign rsp_line_aborted = aborted_ff;
   assign stat.idle        = (state_ff == S_IDLE);
   assign stat.fill        = FILL_W'(fill_ff);

endmodule
`default_nettype wire

// File: hdl/line_edit_buffer_unit.sv
// Top level of the line edit buffer unit: key beats in, finished line characters out.
// Depends on lebu_pkg, lebu_front and lebu_back.
//
// Usage:
//   The req channel takes one key byte per beat (req_valid / req_stall). The
//   front classifies it in the cycle it arrives and, unless the byte is
//   ignored, pushes a command into a two-entry queue; req_stall rises only
//   while that queue is full. The back pops one command at a time.
//   Append, backspace and clear finish in the idle state. Word erase reads
//   and compares each character examined, in turn. A line end puts out one
//   rsp beat per held character, each read through the registered read port
//   of the line store, or a single empty beat. The rsp channel is a single
//   output register: while rsp_stall is high the beat holds and the back
//   waits to load the next one, and the front keeps taking key beats until
//   the queue fills. Bytes of 128 and above, tab and unused control codes
//   are taken and dropped.
//   Reset (synchronous, active high) empties the queue and the output
//   register and zeroes the fill count; the line store itself is not
//   cleared and needs no clearing pass, since only written entries are read.
`timescale 1ns / 1ps
`default_nettype none
module line_edit_buffer_unit #(
   parameter int LINE_DEPTH = lebu_pkg::LINE_DEPTH_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_key_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_line_char,
   output logic            rsp_run_last,
   output logic            rsp_line_empty,
   output logic            rsp_line_aborted
);
   import lebu_pkg::*;

   qout_type q_link;
   logic     q_pop;
   stat_type stat;

   // Front: accept and classify key beats, queue the commands
   lebu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_key_byte (req_key_byte),
      .q_out        (q_link),
      .q_pop        (q_pop)
   );

   // Back: edit the line store and emit finished lines
   lebu_back #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_in             (q_link),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_char    (rsp_line_char),
      .rsp_run_last     (rsp_run_last),
      .rsp_line_empty   (rsp_line_empty),
      .rsp_line_aborted (rsp_line_aborted),
      .stat             (stat)
   );

   // Nothing is shown right after reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // An empty-line marker is a one-beat run carrying a zero character
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_empty |-> rsp_run_last && rsp_line_char == 7'd0)
      else $error("empty marker malformed");

   // A pending beat that is not the last means the back is still in the run
   a_run_in_progress: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_run_last |-> !stat.idle)
      else $error("back idle in the middle of a run");

   // Fill count never passes the line capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      stat.fill <= FILL_W'(LINE_DEPTH - 1))
      else $error("fill count beyond capacity");

endmodule
`default_nettype wire

// File: sim/line_edit_buffer_unit_tb.sv
// Self-checking testbench for line_edit_buffer_unit: key beats in, finished line beats out.
// Depends on lebu_pkg and line_edit_buffer_unit; the expected line beats come from a local
// line editor model that is updated on every accepted key beat.
`timescale 1ns / 1ps
module line_edit_buffer_unit_tb;
   import lebu_pkg::*;

   localparam int LINE_DEPTH = LINE_DEPTH_DEF;
   localparam int HOLD_CYCLES = 400;      // long receiver hold-off in the pressure phase
   localparam int DRAIN_CYCLES = 300;     // covers a full line run plus slack
   localparam logic [4:0] KEY_TAB = 5'h09;
   localparam logic [7:0] KEY_RUBOUT = 8'h7F;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
      logic       empty;
      logic       aborted;
   } line_beat_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_key_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [6:0] rsp_line_char;
   logic       rsp_run_last;
   logic       rsp_line_empty;
   logic       rsp_line_aborted;

   // Key bytes waiting to be offered, and line beats the editor owes us
   logic [7:0]    key_queue[$];
   line_beat_type beats_due[$];

   // Local copy of the editor state
   logic [6:0]  model_line[LINE_DEPTH];
   int unsigned model_fill = 0;

   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        hold_go = 1'b0;
   logic        rsp_hold = 1'b0;
   int unsigned keys_counted = 0;
   int unsigned mismatches = 0;

   line_edit_buffer_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_byte     (req_key_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_char    (rsp_line_char),
      .rsp_run_last     (rsp_run_last),
      .rsp_line_empty   (rsp_line_empty),
      .rsp_line_aborted (rsp_line_aborted)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Line editor model
   // ---------------------------------------------------------------------

   // Queue the beats of a finished line, then clear the line.
   // An empty line still owes one beat, flagged empty and last.
   function automatic void close_line(logic aborted);
      line_beat_type b;
      if (model_fill == 0) begin
         b = '{ch: 7'd0, last: 1'b1, empty: 1'b1, aborted: aborted};
         beats_due.push_back(b);
      end else begin
         for (int k = 0; k < model_fill; k++) begin
            b = '{ch: model_line[k], last: (k == model_fill - 1), empty: 1'b0,
                  aborted: aborted};
            beats_due.push_back(b);
         end
      end
      model_fill = 0;
   endfunction

   // Advance the model by one accepted key byte.
   function automatic void apply_key(logic [7:0] key);
      // High bytes never reach the line
      if (key[7])
         return;
      // Printable: append while there is room, drop when the line is full
      if (key >= KEY_PRINT_LO && key <= KEY_PRINT_HI) begin
         if (model_fill < LINE_DEPTH - 1) begin
            model_line[model_fill] = key[6:0];
            model_fill++;
         end
         return;
      end
      // Control bytes (and rubout) decode on their low five bits
      case (key[4:0])
         KEY_CTRL_C: close_line(1'b1);
         KEY_CTRL_D, KEY_CTRL_J, KEY_CTRL_M: close_line(1'b0);
         KEY_CTRL_H, KEY_DEL: begin
            if (model_fill > 0)
               model_fill--;
         end
         KEY_CTRL_U: model_fill = 0;
         KEY_CTRL_W: begin
            // Strip trailing spaces first, then the word in front of them
            while (model_fill > 0 && model_line[model_fill - 1] == CHAR_SPACE)
               model_fill--;
            while (model_fill > 0 && model_line[model_fill - 1] != CHAR_SPACE)
               model_fill--;
         end
         default: ;   // tab completion and unused codes do nothing
      endcase
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: offer key beats from key_queue, hold while stalled
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_keys
      logic offer;
      offer = req_valid;
      if (reset) begin
         offer = 1'b0;
      end else begin
         // Accepted beat: update the model, free the slot
         if (req_valid && !req_stall) begin
            apply_key(req_key_byte);
            offer = 1'b0;
         end
         // Empty slot: present the next key unless this cycle idles
         if (!offer && key_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_key_byte <= key_queue.pop_front();
            offer = 1'b1;
         end
      end
      // One assignment per edge keeps valid high across back-to-back beats
      req_valid <= offer;
   end

   // Receiver: random stalls, plus the long hold-off when requested
   always @(posedge clock) begin : drive_stall
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= rsp_hold || ($urandom_range(99) < stall_pct);
   end

   // Long hold-off, counted in cycles here so the stimulus keeps flowing meanwhile
   initial begin : hold_off
      wait (hold_go);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each accepted line beat with the oldest one due
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : check_beats
      line_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beats_due.size() == 0) begin
            report_mismatch("unexpected beat, line_char", rsp_line_char, 0);
         end else begin
            want = beats_due.pop_front();
            if (rsp_line_char !== want.ch)
               report_mismatch("line_char", rsp_line_char, want.ch);
            if (rsp_run_last !== want.last)
               report_mismatch("run_last", rsp_run_last, want.last);
            if (rsp_line_empty !== want.empty)
               report_mismatch("line_empty", rsp_line_empty, want.empty);
            if (rsp_line_aborted !== want.aborted)
               report_mismatch("line_aborted", rsp_line_aborted, want.aborted);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic push_key(logic [7:0] key);
      key_queue.push_back(key);
      if (!key[7])
         keys_counted++;
   endtask

   // Mostly letters and punctuation, about one in five a space so word erase has work
   function automatic logic [7:0] random_printable();
      if ($urandom_range(99) < 20)
         return KEY_PRINT_LO;
      return 8'($urandom_range(8'h21, KEY_PRINT_HI));
   endfunction

   // Editing keys and junk that may land inside a line
   function automatic logic [7:0] random_edit_key();
      logic [4:0] code;
      case ($urandom_range(7))
         0: return {3'b000, KEY_CTRL_H};
         1: return KEY_RUBOUT;
         2: return {3'b000, KEY_DEL};
         3: return {3'b000, KEY_CTRL_W};
         4: begin
            // Keep line clears rare so most lines reach their end with text
            if ($urandom_range(3) == 0)
               return {3'b000, KEY_CTRL_U};
            return {3'b000, KEY_CTRL_W};
         end
         5: return {3'b000, KEY_TAB};
         6: return 8'($urandom_range(128, 255));
         default: begin
            // Control codes with no action
            do
               code = 5'($urandom_range(31));
            while (code inside {KEY_CTRL_C, KEY_CTRL_D, KEY_CTRL_J, KEY_CTRL_M,
                                KEY_CTRL_H, KEY_DEL, KEY_CTRL_U, KEY_CTRL_W});
            return {3'b000, code};
         end
      endcase
   endfunction

   // Type one line of len keys, optionally mixed with edits, then end it
   task automatic type_line(int unsigned len, bit with_edits);
      for (int i = 0; i < len; i++) begin
         if (with_edits && $urandom_range(99) < 20)
            push_key(random_edit_key());
         else
            push_key(random_printable());
      end
      case ($urandom_range(3))
         0: push_key({3'b000, KEY_CTRL_C});
         1: push_key({3'b000, KEY_CTRL_D});
         2: push_key({3'b000, KEY_CTRL_J});
         default: push_key({3'b000, KEY_CTRL_M});
      endcase
   endtask

   // Wait until every key is accepted and every owed beat has come out
   task automatic wait_drained();
      while (key_queue.size() != 0 || req_valid || beats_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin : stimulus
      int unsigned snd_pct[4] = '{0, 56, 0, 32};
      int unsigned rcv_pct[4] = '{0, 0, 56, 32};
      int unsigned len;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: line ends, edits and ignored keys on an empty line first
      push_key({3'b000, KEY_CTRL_M});      // empty line, normal end
      push_key({3'b000, KEY_CTRL_C});      // empty line, aborted
      push_key({3'b000, KEY_CTRL_H});      // edits on an empty line do nothing
      push_key({3'b000, KEY_CTRL_W});
      push_key({3'b000, KEY_CTRL_U});
      push_key({3'b000, KEY_TAB});
      push_key(8'h80);                     // high bytes are ignored
      push_key(8'hFF);
      push_key(8'h00);                     // unused control code
      // Printable extremes, both rubout forms, then word erase over trailing spaces
      push_key(KEY_PRINT_LO);
      push_key(KEY_PRINT_HI);
      push_key(8'h61);
      push_key(KEY_RUBOUT);
      push_key(8'h62);
      push_key({3'b000, KEY_DEL});
      push_key(8'h78);
      push_key(8'h79);
      push_key(KEY_PRINT_LO);
      push_key(KEY_PRINT_LO);
      push_key({3'b000, KEY_CTRL_W});
      push_key({3'b000, KEY_CTRL_D});
      // Clear, retype, end with ctrl-J; then an aborted one-char line
      push_key(8'h71);
      push_key({3'b000, KEY_CTRL_U});
      push_key(8'h72);
      push_key({3'b000, KEY_CTRL_J});
      push_key(8'h7A);
      push_key({3'b000, KEY_CTRL_C});

      // Random lines through the idling phases; drain each phase before the next
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = snd_pct[ph];
         stall_pct = rcv_pct[ph];
         // Overfill one line so the drop-when-full path and the longest run appear
         if (ph == 0 || ph == 3)
            type_line(LINE_DEPTH + 6, 1'b0);
         while (keys_counted < 25 + (ph + 1) * 67) begin
            case ($urandom_range(19))
               0: len = $urandom_range(40, LINE_DEPTH + 8);
               1, 2: len = $urandom_range(13, 40);
               default: len = $urandom_range(0, 12);
            endcase
            type_line(len, 1'b1);
         end
         wait_drained();
      end

      // Pressure: hold off the receiver while keys keep coming, so the
      // command queue fills and req_stall rises
      wait_drained();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_go = 1'b1;
      type_line(40, 1'b0);
      type_line(6, 1'b1);
      type_line(5, 1'b1);
      type_line(8, 1'b1);

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (beats_due.size() != 0)
         report_mismatch("line beats never delivered", 0, beats_due.size());
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Hard limit on the run
   initial begin : watchdog
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
